/* rtl/core/stl_pkg.sv */
`default_nettype none

package stl_pkg;

  localparam int TOKEN_LIMIT = 4096;
  localparam int TEXT_MAX = 255;
  localparam int NUMBER_TEXT_MAX = 63;
  localparam int KW_COUNT = 49;
  localparam int KW_OWN = 21;
  localparam int KW_CHARS_MAX = 12;

  localparam logic [12:0] TOKEN_STOP = 13'(TOKEN_LIMIT - 1);
  localparam logic [7:0] TEXT_LAST = 8'(TEXT_MAX);
  localparam logic [7:0] NUM_TEXT_LAST = 8'(NUMBER_TEXT_MAX);
  localparam logic [47:0] MANT_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [23:0] LINE_SAT = 24'hFF_FFFF;
  localparam logic [15:0] COL_SAT = 16'hFFFF;

  // Record kinds
  localparam logic [1:0] RK_TEXT = 2'd0;
  localparam logic [1:0] RK_TOKEN = 2'd1;
  localparam logic [1:0] RK_DIAG = 2'd2;

  // Diagnostic codes
  localparam logic [1:0] ERR_UNTERM = 2'd0;
  localparam logic [1:0] ERR_AMP = 2'd1;
  localparam logic [1:0] ERR_BAR = 2'd2;
  localparam logic [1:0] ERR_CHAR = 2'd3;

  // Token kinds
  localparam logic [5:0] K_END = 6'd0;
  localparam logic [5:0] K_NUMBER = 6'd1;
  localparam logic [5:0] K_IDENT = 6'd2;
  localparam logic [5:0] K_STRING = 6'd3;
  localparam logic [5:0] K_KW_BASE = 6'd4;
  localparam logic [5:0] K_BUILTIN = 6'd25;
  localparam logic [5:0] K_ASSIGN = 6'd26;
  localparam logic [5:0] K_ADD = 6'd27;
  localparam logic [5:0] K_SUB = 6'd28;
  localparam logic [5:0] K_MUL = 6'd29;
  localparam logic [5:0] K_DIV = 6'd30;
  localparam logic [5:0] K_LPAREN = 6'd31;
  localparam logic [5:0] K_RPAREN = 6'd32;
  localparam logic [5:0] K_LBRACE = 6'd33;
  localparam logic [5:0] K_RBRACE = 6'd34;
  localparam logic [5:0] K_LBRACKET = 6'd35;
  localparam logic [5:0] K_RBRACKET = 6'd36;
  localparam logic [5:0] K_DOT = 6'd37;
  localparam logic [5:0] K_SEMI = 6'd38;
  localparam logic [5:0] K_COMMA = 6'd39;
  localparam logic [5:0] K_LT = 6'd40;
  localparam logic [5:0] K_GT = 6'd41;
  localparam logic [5:0] K_LE = 6'd42;
  localparam logic [5:0] K_GE = 6'd43;
  localparam logic [5:0] K_EQ = 6'd44;
  localparam logic [5:0] K_NE = 6'd45;
  localparam logic [5:0] K_AND = 6'd46;
  localparam logic [5:0] K_OR = 6'd47;
  localparam logic [5:0] K_NOT = 6'd48;

  // Characters
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_BAR = 8'h7C;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;

  typedef enum logic [2:0] {
    M_IDLE, M_NUMBER, M_IDENT, M_STRING, M_ESC, M_COMMENT, M_PEND
  } mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [5:0]  token_kind;
    logic [7:0]  text_byte;
    logic [23:0] line_number;
    logic [15:0] column_number;
    logic [7:0]  lexeme_length;
    logic [47:0] number_mantissa;
    logic [5:0]  fraction_digits;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  // All records caused by one accepted item.
  typedef struct packed {
    logic [1:0]           count;
    out_item_t [2:0]      recs;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Keywords are stored right-justified; the first 21 have their own kinds.
  localparam logic [87:0] KW_TEXT [KW_COUNT] = '{
    "let", "print", "sim", "step", "dt", "if", "else", "true", "false",
    "while", "break", "continue", "fn", "parallel", "for", "in", "const",
    "return", "vec3", "mat4", "particle",
    "dot", "cross", "length", "normalize", "sqrt", "abs", "min", "max",
    "sin", "cos", "tan", "translate", "rotate", "scale", "transform", "len",
    "integrate", {"apply", "_force"}, {"clear", "_force"}, "pow", "exp", "log", "floor",
    "ceil", "round", "clamp", "lerp", "reflect"
  };

  typedef logic [KW_CHARS_MAX-1:0][7:0] kw_row_t;
  typedef kw_row_t [KW_COUNT-1:0] kw_chars_t;
  typedef logic [KW_COUNT-1:0][3:0] kw_lens_t;

  function automatic kw_lens_t build_lens();
    kw_lens_t r;
    r = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      for (int i = 0; i < 11; i++) begin
        if (KW_TEXT[k][8*i +: 8] != 8'h00) r[k] = 4'(i + 1);
      end
    end
    return r;
  endfunction

  localparam kw_lens_t KW_LEN = build_lens();

  // Left-justified characters, zero past the end of each keyword.
  function automatic kw_chars_t build_chars();
    kw_chars_t r;
    r = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      for (int i = 0; i < 11; i++) begin
        if (i < int'(KW_LEN[k])) r[k][i] = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8];
      end
    end
    return r;
  endfunction

  localparam kw_chars_t KW_CHARS = build_chars();

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // Drops every keyword whose character at this position differs, and all of them from position 12 on.
  function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] cand,
                                                   input logic [7:0] pos,
                                                   input logic [7:0] b);
    logic [KW_COUNT-1:0] r;
    logic [3:0] idx;
    r = cand;
    idx = (pos < 8'(KW_CHARS_MAX)) ? pos[3:0] : 4'd0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((pos >= 8'(KW_CHARS_MAX)) || (KW_CHARS[k][idx] != b)) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [5:0] kw_kind(input logic [KW_COUNT-1:0] cand,
                                        input logic [7:0] len);
    logic [5:0] r;
    r = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && (len == {4'd0, KW_LEN[k]})) begin
        r = (k < KW_OWN) ? 6'(int'(K_KW_BASE) + k) : K_BUILTIN;
      end
    end
    return r;
  endfunction

  // Decimal step: top bit set when the result would pass the 48-bit range.
  function automatic logic [48:0] mant_step(input logic [47:0] m, input logic [3:0] d);
    logic [51:0] w;
    w = {1'b0, m, 3'b000} + {3'b000, m, 1'b0} + {48'd0, d};
    if (w > {4'd0, MANT_MAX}) return {1'b1, MANT_MAX};
    return {1'b0, w[47:0]};
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] p);
    logic [5:0] r;
    unique case (p)
      CH_SLASH: r = K_DIV;
      CH_DOT:   r = K_DOT;
      CH_EQ:    r = K_ASSIGN;
      CH_BANG:  r = K_NOT;
      CH_LT:    r = K_LT;
      default:  r = K_GT;
    endcase
    return r;
  endfunction

  function automatic out_item_t text_rec(input logic [7:0] b, input logic [23:0] ln,
                                         input logic [15:0] col);
    out_item_t r;
    r = '0;
    r.record_kind = RK_TEXT;
    r.text_byte = b;
    r.line_number = ln;
    r.column_number = col;
    return r;
  endfunction

  function automatic out_item_t tok_rec(input logic [5:0] kind, input logic [23:0] ln,
                                        input logic [15:0] col, input logic [7:0] len,
                                        input logic [47:0] mant, input logic [5:0] frac);
    out_item_t r;
    r = '0;
    r.record_kind = RK_TOKEN;
    r.token_kind = kind;
    r.line_number = ln;
    r.column_number = col;
    r.lexeme_length = len;
    r.number_mantissa = mant;
    r.fraction_digits = frac;
    return r;
  endfunction

  function automatic out_item_t diag_rec(input logic [1:0] code, input logic [23:0] ln,
                                         input logic [15:0] col);
    out_item_t r;
    r = '0;
    r.record_kind = RK_DIAG;
    r.line_number = ln;
    r.column_number = col;
    r.error_code = code;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/stl_front.sv */
`default_nettype none

// Lexer front: one byte a cycle unless stalled; builds the records it causes.
module stl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire stl_pkg::in_item_t in_data,
  output logic                   in_stall,
  input  wire stl_pkg::q_stat_t  q_stat,
  output logic                   push,
  output stl_pkg::bundle_t       push_data
);

  stl_pkg::mode_t              mode_r, mode_nxt, md;
  logic [7:0]                  pc_r, pc_nxt, pc;
  logic [23:0]                 line_r, line_nxt, ln;
  logic [15:0]                 col_r, col_nxt, col;
  logic [15:0]                 tsc_r, tsc_nxt, tsc;
  logic [7:0]                  tl_r, tl_nxt, tl;
  logic [47:0]                 mant_r, mant_nxt, mant;
  logic [5:0]                  fc_r, fc_nxt, fc;
  logic [1:0]                  dots_r, dots_nxt, dots;
  logic [stl_pkg::KW_COUNT-1:0] cand_r, cand_nxt, cand;
  logic [12:0]                 tok_r, tok_nxt, tok;
  logic                        sat_r, sat_nxt, sat;
  stl_pkg::out_item_t [2:0]    rr;
  logic [1:0]                  n;
  logic                        fr;
  logic [7:0]                  b, p;
  logic [48:0]                 ms;
  logic [5:0]                  k;
  logic                        accept;

  assign in_stall = q_stat.full;
  assign accept = in_valid && !in_stall;

  always_comb begin
    md = mode_r; pc = pc_r; ln = line_r; col = col_r; tsc = tsc_r; tl = tl_r;
    mant = mant_r; fc = fc_r; dots = dots_r; cand = cand_r; tok = tok_r; sat = sat_r;
    rr = '0; n = 2'd0; fr = 1'b0; b = in_data.source_byte; p = pc_r; ms = '0;
    k = stl_pkg::K_END;

    if (in_data.end_of_source) begin
      if (tok_r < stl_pkg::TOKEN_STOP) begin
        unique case (mode_r)
          stl_pkg::M_NUMBER: begin
            rr[n] = stl_pkg::tok_rec(stl_pkg::K_NUMBER, ln, tsc, tl, mant, fc);
            n = n + 2'd1;
          end
          stl_pkg::M_IDENT: begin
            rr[n] = stl_pkg::tok_rec(stl_pkg::kw_kind(cand, tl), ln, tsc, tl, '0, '0);
            n = n + 2'd1;
          end
          stl_pkg::M_STRING, stl_pkg::M_ESC: begin
            rr[n] = stl_pkg::diag_rec(stl_pkg::ERR_UNTERM, ln, tsc);
            n = n + 2'd1;
            rr[n] = stl_pkg::tok_rec(stl_pkg::K_STRING, ln, tsc, tl, '0, '0);
            n = n + 2'd1;
          end
          stl_pkg::M_PEND: begin
            if (pc == stl_pkg::CH_AMP) begin
              rr[n] = stl_pkg::diag_rec(stl_pkg::ERR_AMP, ln, tsc);
            end else if (pc == stl_pkg::CH_BAR) begin
              rr[n] = stl_pkg::diag_rec(stl_pkg::ERR_BAR, ln, tsc);
            end else begin
              rr[n] = stl_pkg::tok_rec(stl_pkg::single_kind(pc), ln, tsc, '0, '0, '0);
            end
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
      end
      if (n != 2'd3) begin
        rr[n] = stl_pkg::tok_rec(stl_pkg::K_END, ln, col, '0, '0, '0);
        n = n + 2'd1;
      end
      md = stl_pkg::M_IDLE; pc = '0; ln = 24'd1; col = 16'd1; tsc = 16'd1; tl = '0;
      mant = '0; fc = '0; dots = '0; cand = '1; tok = '0; sat = 1'b0;
    end else if (tok_r < stl_pkg::TOKEN_STOP) begin
      unique case (mode_r)
        stl_pkg::M_NUMBER: begin
          if (stl_pkg::is_digit(b) || (b == stl_pkg::CH_DOT)) begin
            if (col != stl_pkg::COL_SAT) col = col + 16'd1;
            rr[n] = stl_pkg::text_rec(b, ln, tsc);
            n = n + 2'd1;
            tl = tl + 8'd1;
            if (b == stl_pkg::CH_DOT) begin
              if (dots != 2'd2) dots = dots + 2'd1;
            end else if ((dots != 2'd2) && !sat) begin
              ms = stl_pkg::mant_step(mant, b[3:0]);
              mant = ms[47:0];
              if (ms[48]) begin
                sat = 1'b1;
              end else if (dots == 2'd1) begin
                fc = fc + 6'd1;
              end
            end
            if (tl >= stl_pkg::NUM_TEXT_LAST) begin
              rr[n] = stl_pkg::tok_rec(stl_pkg::K_NUMBER, ln, tsc, tl, mant, fc);
              n = n + 2'd1;
              tok = tok + 13'd1;
              md = stl_pkg::M_IDLE;
            end
          end else begin
            rr[n] = stl_pkg::tok_rec(stl_pkg::K_NUMBER, ln, tsc, tl, mant, fc);
            n = n + 2'd1;
            tok = tok + 13'd1;
            md = stl_pkg::M_IDLE;
            fr = 1'b1;
          end
        end
        stl_pkg::M_IDENT: begin
          if (stl_pkg::is_alpha(b) || stl_pkg::is_digit(b) || (b == stl_pkg::CH_UNDER)) begin
            if (col != stl_pkg::COL_SAT) col = col + 16'd1;
            cand = stl_pkg::kw_filter(cand, tl, b);
            rr[n] = stl_pkg::text_rec(b, ln, tsc);
            n = n + 2'd1;
            tl = tl + 8'd1;
            if (tl >= stl_pkg::TEXT_LAST) begin
              rr[n] = stl_pkg::tok_rec(stl_pkg::kw_kind(cand, tl), ln, tsc, tl, '0, '0);
              n = n + 2'd1;
              tok = tok + 13'd1;
              md = stl_pkg::M_IDLE;
            end
          end else begin
            rr[n] = stl_pkg::tok_rec(stl_pkg::kw_kind(cand, tl), ln, tsc, tl, '0, '0);
            n = n + 2'd1;
            tok = tok + 13'd1;
            md = stl_pkg::M_IDLE;
            fr = 1'b1;
          end
        end
        stl_pkg::M_STRING: begin
          if (b == stl_pkg::CH_NL) begin
            rr[n] = stl_pkg::diag_rec(stl_pkg::ERR_UNTERM, ln, tsc);
            n = n + 2'd1;
            rr[n] = stl_pkg::tok_rec(stl_pkg::K_STRING, ln, tsc, tl, '0, '0);
            n = n + 2'd1;
            tok = tok + 13'd1;
            md = stl_pkg::M_IDLE;
            fr = 1'b1;
          end else if (b == stl_pkg::CH_QUOTE) begin
            if (col != stl_pkg::COL_SAT) col = col + 16'd1;
            rr[n] = stl_pkg::tok_rec(stl_pkg::K_STRING, ln, tsc, tl, '0, '0);
            n = n + 2'd1;
            tok = tok + 13'd1;
            md = stl_pkg::M_IDLE;
          end else if (b == stl_pkg::CH_BSLASH) begin
            if (col != stl_pkg::COL_SAT) col = col + 16'd1;
            md = stl_pkg::M_ESC;
          end else begin
            if (col != stl_pkg::COL_SAT) col = col + 16'd1;
            if (tl < stl_pkg::TEXT_LAST) begin
              rr[n] = stl_pkg::text_rec(b, ln, tsc);
              n = n + 2'd1;
              tl = tl + 8'd1;
            end
          end
        end
        stl_pkg::M_ESC: begin
          if (col != stl_pkg::COL_SAT) col = col + 16'd1;
          if (tl < stl_pkg::TEXT_LAST) begin
            if (b == stl_pkg::CH_LOWER_N) begin
              rr[n] = stl_pkg::text_rec(stl_pkg::CH_NL, ln, tsc);
            end else if (b == stl_pkg::CH_LOWER_T) begin
              rr[n] = stl_pkg::text_rec(stl_pkg::CH_TAB, ln, tsc);
            end else begin
              rr[n] = stl_pkg::text_rec(b, ln, tsc);
            end
            n = n + 2'd1;
            tl = tl + 8'd1;
          end
          md = stl_pkg::M_STRING;
        end
        stl_pkg::M_COMMENT: begin
          if (b == stl_pkg::CH_NL) begin
            fr = 1'b1;
          end else if (col != stl_pkg::COL_SAT) begin
            col = col + 16'd1;
          end
        end
        stl_pkg::M_PEND: begin
          if ((p == stl_pkg::CH_SLASH) && (b == stl_pkg::CH_SLASH)) begin
            if (col != stl_pkg::COL_SAT) col = col + 16'd1;
            md = stl_pkg::M_COMMENT;
          end else if ((p == stl_pkg::CH_DOT) && stl_pkg::is_digit(b)) begin
            // A dot followed by a digit opens a number with one dot seen.
            md = stl_pkg::M_NUMBER; sat = 1'b0;
            rr[n] = stl_pkg::text_rec(stl_pkg::CH_DOT, ln, tsc);
            n = n + 2'd1;
            if (col != stl_pkg::COL_SAT) col = col + 16'd1;
            rr[n] = stl_pkg::text_rec(b, ln, tsc);
            n = n + 2'd1;
            tl = 8'd2; dots = 2'd1; mant = {44'd0, b[3:0]}; fc = 6'd1;
          end else if ((p == stl_pkg::CH_AMP) || (p == stl_pkg::CH_BAR)) begin
            if (b == p) begin
              if (col != stl_pkg::COL_SAT) col = col + 16'd1;
              k = (p == stl_pkg::CH_AMP) ? stl_pkg::K_AND : stl_pkg::K_OR;
              rr[n] = stl_pkg::tok_rec(k, ln, tsc, '0, '0, '0);
              n = n + 2'd1;
              tok = tok + 13'd1;
              md = stl_pkg::M_IDLE;
            end else begin
              rr[n] = stl_pkg::diag_rec((p == stl_pkg::CH_AMP) ? stl_pkg::ERR_AMP :
                                        stl_pkg::ERR_BAR, ln, tsc);
              n = n + 2'd1;
              md = stl_pkg::M_IDLE;
              fr = 1'b1;
            end
          end else if ((p != stl_pkg::CH_SLASH) && (p != stl_pkg::CH_DOT) &&
                       (b == stl_pkg::CH_EQ)) begin
            if (col != stl_pkg::COL_SAT) col = col + 16'd1;
            k = (p == stl_pkg::CH_EQ) ? stl_pkg::K_EQ : (p == stl_pkg::CH_BANG) ? stl_pkg::K_NE :
                (p == stl_pkg::CH_LT) ? stl_pkg::K_LE : stl_pkg::K_GE;
            rr[n] = stl_pkg::tok_rec(k, ln, tsc, '0, '0, '0);
            n = n + 2'd1;
            tok = tok + 13'd1;
            md = stl_pkg::M_IDLE;
          end else begin
            rr[n] = stl_pkg::tok_rec(stl_pkg::single_kind(p), ln, tsc, '0, '0, '0);
            n = n + 2'd1;
            tok = tok + 13'd1;
            md = stl_pkg::M_IDLE;
            fr = 1'b1;
          end
        end
        default: begin
          fr = 1'b1;
        end
      endcase

      // The byte starts afresh, unless the token just closed reached the limit.
      if (fr && (tok < stl_pkg::TOKEN_STOP)) begin
        md = stl_pkg::M_IDLE;
        tsc = col;
        if (b == stl_pkg::CH_NL) begin
          if (ln != stl_pkg::LINE_SAT) ln = ln + 24'd1;
          col = 16'd1;
        end else if ((b <= stl_pkg::CH_SPACE) || (b >= stl_pkg::CH_DEL)) begin
          if (col != stl_pkg::COL_SAT) col = col + 16'd1;
        end else if (stl_pkg::is_digit(b)) begin
          md = stl_pkg::M_NUMBER; sat = 1'b0; dots = 2'd0; fc = 6'd0;
          if (col != stl_pkg::COL_SAT) col = col + 16'd1;
          if (n != 2'd3) begin
            rr[n] = stl_pkg::text_rec(b, ln, tsc);
            n = n + 2'd1;
          end
          tl = 8'd1; mant = {44'd0, b[3:0]};
        end else if (stl_pkg::is_alpha(b) || (b == stl_pkg::CH_UNDER)) begin
          md = stl_pkg::M_IDENT;
          if (col != stl_pkg::COL_SAT) col = col + 16'd1;
          cand = stl_pkg::kw_filter('1, 8'd0, b);
          if (n != 2'd3) begin
            rr[n] = stl_pkg::text_rec(b, ln, tsc);
            n = n + 2'd1;
          end
          tl = 8'd1;
        end else if (b == stl_pkg::CH_QUOTE) begin
          md = stl_pkg::M_STRING; tl = 8'd0;
          if (col != stl_pkg::COL_SAT) col = col + 16'd1;
        end else begin
          unique case (b) inside
            stl_pkg::CH_DOT, stl_pkg::CH_SLASH, stl_pkg::CH_EQ, stl_pkg::CH_BANG,
            stl_pkg::CH_LT, stl_pkg::CH_GT, stl_pkg::CH_AMP, stl_pkg::CH_BAR: begin
              md = stl_pkg::M_PEND; pc = b;
            end
            stl_pkg::CH_PLUS:     k = stl_pkg::K_ADD;
            stl_pkg::CH_MINUS:    k = stl_pkg::K_SUB;
            stl_pkg::CH_STAR:     k = stl_pkg::K_MUL;
            stl_pkg::CH_LPAREN:   k = stl_pkg::K_LPAREN;
            stl_pkg::CH_RPAREN:   k = stl_pkg::K_RPAREN;
            stl_pkg::CH_LBRACE:   k = stl_pkg::K_LBRACE;
            stl_pkg::CH_RBRACE:   k = stl_pkg::K_RBRACE;
            stl_pkg::CH_LBRACKET: k = stl_pkg::K_LBRACKET;
            stl_pkg::CH_RBRACKET: k = stl_pkg::K_RBRACKET;
            stl_pkg::CH_SEMI:     k = stl_pkg::K_SEMI;
            stl_pkg::CH_COMMA:    k = stl_pkg::K_COMMA;
            default: begin
              if (n != 2'd3) begin
                rr[n] = stl_pkg::diag_rec(stl_pkg::ERR_CHAR, ln, col);
                n = n + 2'd1;
              end
            end
          endcase
          if (k != stl_pkg::K_END) begin
            if (n != 2'd3) begin
              rr[n] = stl_pkg::tok_rec(k, ln, tsc, '0, '0, '0);
              n = n + 2'd1;
            end
            tok = tok + 13'd1;
          end
          if (col != stl_pkg::COL_SAT) col = col + 16'd1;
        end
      end
    end

    mode_nxt = md; pc_nxt = pc; line_nxt = ln; col_nxt = col; tsc_nxt = tsc; tl_nxt = tl;
    mant_nxt = mant; fc_nxt = fc; dots_nxt = dots; cand_nxt = cand; tok_nxt = tok;
    sat_nxt = sat;
  end

  assign push = accept && (n != 2'd0);
  assign push_data = '{count: n, recs: rr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stl_pkg::M_IDLE;
      pc_r <= '0;
      line_r <= 24'd1;
      col_r <= 16'd1;
      tsc_r <= 16'd1;
      tl_r <= '0;
      mant_r <= '0;
      fc_r <= '0;
      dots_r <= '0;
      cand_r <= '1;
      tok_r <= '0;
      sat_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pc_r <= pc_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
      tsc_r <= tsc_nxt;
      tl_r <= tl_nxt;
      mant_r <= mant_nxt;
      fc_r <= fc_nxt;
      dots_r <= dots_nxt;
      cand_r <= cand_nxt;
      tok_r <= tok_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stl_queue.sv */
`default_nettype none

// Two-entry queue of record bundles between the front and the back.
module stl_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire stl_pkg::bundle_t push_data,
  input  wire logic             pop,
  output stl_pkg::bundle_t      head,
  output stl_pkg::q_stat_t      stat
);

  stl_pkg::bundle_t slot_r [2];
  logic             wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign head = slot_r[rd_r];
  assign stat = '{full: (cnt_r == 2'd2), empty: (cnt_r == 2'd0)};

  always_comb begin
    wr_nxt = push ? !wr_r : wr_r;
    rd_nxt = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stl_back.sv */
`default_nettype none

// Back end: hands out the records of each bundle one a cycle unless stalled.
module stl_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire stl_pkg::bundle_t head,
  input  wire stl_pkg::q_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output stl_pkg::out_item_t    out_data
);

  logic               out_valid_r, out_valid_nxt;
  stl_pkg::out_item_t out_r, out_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic               take, is_last;

  assign take = (!out_valid_r || !out_stall) && !stat.empty;
  assign is_last = (sub_r == (head.count - 2'd1)) || (sub_r == 2'd2);
  assign pop = take && is_last;

  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    sub_nxt = sub_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = !stat.empty;
      out_nxt = head.recs[sub_r];
      out_nxt.last = is_last;
    end
    if (take) sub_nxt = is_last ? 2'd0 : sub_r + 2'd1;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r <= sub_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/source_tokenizer.sv */
// Channel  Direction  Payload                Handshake
// in_      input      stl_pkg::in_item_t     in_valid / in_stall
// out_     output     stl_pkg::out_item_t    out_valid / out_stall
//
// The front lexes one byte in the cycle it is accepted; its records go into a
// two-entry bundle queue. The back register hands out one record per cycle
// unless stalled or the queue is empty; an item makes one to three records, and
// a byte that makes no record pushes nothing. Reset is synchronous and active
// low; it empties the queue and returns the lexer to the start of a line.
// A stalled output fills the queue, after which in_stall rises.
`default_nettype none

module source_tokenizer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire stl_pkg::in_item_t  in_data,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output stl_pkg::out_item_t      out_data
);

  logic             push, pop;
  stl_pkg::bundle_t push_data, head;
  stl_pkg::q_stat_t q_stat;

  // Front: the lexer state and the keyword candidate set.
  stl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: lets the lexer run on while earlier records wait to be taken.
  stl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back: serialises each bundle and marks its final record.
  stl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/core/stl_checker.sv */
`default_nettype none

module stl_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire stl_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled record changed");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.record_kind != stl_pkg::RK_TOKEN + stl_pkg::RK_DIAG)
    else $error("undefined record kind");

  a_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == stl_pkg::RK_TOKEN |->
      out_data.text_byte == 8'd0 && out_data.error_code == 2'd0)
    else $error("token record carries text or error");

  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_number != 24'd0 && out_data.column_number != 16'd0)
    else $error("position out of range");

endmodule

bind source_tokenizer stl_checker u_stl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
